@@ design/btpc_pkg.sv @@
// package: calibration types, queue entry and rounding helper for the compensation block
`timescale 1ns / 1ps
package btpc_pkg;

  localparam logic [1:0] CFG_CAL_LOW  = 2'd0;
  localparam logic [1:0] CFG_CAL_MID  = 2'd1;
  localparam logic [1:0] CFG_CAL_HIGH = 2'd2;

  localparam logic signed [63:0] TQ_LIMIT = 64'sd134217728;
  localparam logic signed [63:0] TEMP_MAX = 64'sd32767;
  localparam logic signed [63:0] TEMP_MIN = -64'sd32768;
  localparam logic signed [63:0] PRES_MAX = 64'sd16777215;

  typedef struct packed {
    logic        [15:0] t1;
    logic        [15:0] t2;
    logic signed [7:0]  t3;
    logic signed [15:0] p1;
    logic signed [15:0] p2;
    logic signed [7:0]  p3;
    logic signed [7:0]  p4;
    logic        [15:0] p5;
    logic        [15:0] p6;
    logic signed [7:0]  p7;
    logic signed [7:0]  p8;
    logic signed [15:0] p9;
    logic signed [7:0]  p10;
    logic signed [7:0]  p11;
  } coef_t;

  typedef struct packed {
    logic        [23:0] u;
    logic signed [42:0] dt2;
    logic signed [50:0] dd;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic coef_t decode_cal(input logic [63:0] lo, input logic [63:0] mid,
                                       input logic [39:0] hi);
    logic [167:0] b;
    coef_t c;
    b = {hi, mid, lo};
    c.t1  = b[15:0];
    c.t2  = b[31:16];
    c.t3  = $signed(b[39:32]);
    c.p1  = $signed(b[55:40]);
    c.p2  = $signed(b[71:56]);
    c.p3  = $signed(b[79:72]);
    c.p4  = $signed(b[87:80]);
    c.p5  = b[103:88];
    c.p6  = b[119:104];
    c.p7  = $signed(b[127:120]);
    c.p8  = $signed(b[135:128]);
    c.p9  = $signed(b[151:136]);
    c.p10 = $signed(b[159:152]);
    c.p11 = $signed(b[167:160]);
    return c;
  endfunction

  // round half up then arithmetic shift
  function automatic logic signed [63:0] rnd(input logic signed [63:0] v,
                                             input int unsigned s);
    logic signed [63:0] half;
    half = 64'sd1 <<< (s - 1);
    return (v + half) >>> s;
  endfunction

endpackage

@@ design/btpc_if.sv @@
// stream interfaces for raw samples and compensated results
`timescale 1ns / 1ps
interface btpc_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] raw_pressure;
  logic [23:0] raw_temperature;
  modport source(output valid, output raw_pressure, output raw_temperature, input ready);
  modport sink(input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

interface btpc_out_if;
  logic               valid;
  logic               ready;
  logic        [23:0] pressure_out;
  logic signed [15:0] temperature_out;
  logic               saturated;
  modport source(output valid, output pressure_out, output temperature_out,
                 output saturated, input ready);
  modport sink(input valid, input pressure_out, input temperature_out,
               input saturated, output ready);
endinterface

@@ design/baro_temp_pressure_compensation.sv @@
// top level: calibration registers, front end, queue and compensation pipeline
`timescale 1ns / 1ps
// Takes one raw pressure and temperature sample per transaction and returns
// pressure in 1/64 Pa and temperature in 1/256 degC, both saturated, with a flag.
// One transaction is accepted every cycle unless a full queue holds the front
// register; results pass it, the queue and the eight-stage back-end multiply
// pipeline, held on back-pressure. Calibration bytes must be written by the user
// via cfg_we/cfg_index/cfg_wdata only while no sample is in flight (unchecked).
module baro_temp_pressure_compensation #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  btpc_in_if.sink     in_ch,
  btpc_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  logic [63:0] cal_bytes_low;
  logic [63:0] cal_bytes_mid;
  logic [39:0] cal_bytes_high;

  btpc_pkg::coef_t     coef;
  btpc_pkg::q_entry_t  push_data;
  btpc_pkg::q_entry_t  head;
  btpc_pkg::q_status_t q_status;
  logic                push;
  logic                pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_bytes_low  <= '0;
      cal_bytes_mid  <= '0;
      cal_bytes_high <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        btpc_pkg::CFG_CAL_LOW:  cal_bytes_low  <= cfg_wdata;
        btpc_pkg::CFG_CAL_MID:  cal_bytes_mid  <= cfg_wdata;
        btpc_pkg::CFG_CAL_HIGH: cal_bytes_high <= cfg_wdata[39:0];
        default: ;
      endcase
    end
  end

  assign coef = btpc_pkg::decode_cal(cal_bytes_low, cal_bytes_mid, cal_bytes_high);

  btpc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .coef      (coef),
    .in_ch     (in_ch),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  btpc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  btpc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .coef     (coef),
    .q_status (q_status),
    .head     (head),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

@@ design/btpc_front.sv @@
// front end: accepts samples, forms temperature offset and first products
`timescale 1ns / 1ps
module btpc_front (
  input  logic                clk,
  input  logic                rst,
  input  btpc_pkg::coef_t     coef,
  btpc_in_if.sink             in_ch,
  input  btpc_pkg::q_status_t q_status,
  output logic                push,
  output btpc_pkg::q_entry_t  push_data
);

  logic               f_valid;
  logic               f_valid_next;
  logic [23:0]        f_u;
  logic signed [25:0] f_d;
  logic signed [25:0] d_in;
  logic               take;

  assign in_ch.ready = !f_valid || !q_status.full;
  assign take        = in_ch.valid && in_ch.ready;
  assign push        = f_valid && !q_status.full;

  assign d_in = $signed({2'b00, in_ch.raw_temperature}) - $signed({2'b00, coef.t1, 8'h00});

  always_comb begin
    f_valid_next = f_valid;
    if (take) begin
      f_valid_next = 1'b1;
    end else if (push) begin
      f_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= f_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      f_u <= in_ch.raw_pressure;
      f_d <= d_in;
    end
  end

  always_comb begin
    push_data.u   = f_u;
    push_data.dt2 = f_d * $signed({1'b0, coef.t2});
    push_data.dd  = f_d * f_d;
  end

endmodule

@@ design/btpc_queue.sv @@
// small transaction queue between front and back ends
`timescale 1ns / 1ps
module btpc_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  btpc_pkg::q_entry_t  push_data,
  input  logic                pop,
  output btpc_pkg::q_entry_t  head,
  output btpc_pkg::q_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  btpc_pkg::q_entry_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH)) else $error("queue count above depth");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not rise on push");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !do_push) |=> count == $past(count) - 1'b1)
    else $error("queue count did not fall on pop");

endmodule

@@ design/btpc_back.sv @@
// back end: temperature linearization and pressure polynomial pipeline
`timescale 1ns / 1ps
module btpc_back (
  input  logic                clk,
  input  logic                rst,
  input  btpc_pkg::coef_t     coef,
  input  btpc_pkg::q_status_t q_status,
  input  btpc_pkg::q_entry_t  head,
  output logic                pop,
  btpc_out_if.source          out_ch
);

  logic en;
  logic v1, v2, v3, v4, v5, v6, v7;

  // stage 1
  logic [23:0]        s1_u;
  logic signed [60:0] s1_tl;
  // stage 2
  logic [23:0]        s2_u;
  logic signed [28:0] s2_tq;
  logic signed [15:0] s2_temp;
  logic               s2_tsat;
  // stage 3
  logic [23:0]        s3_u;
  logic signed [28:0] s3_tq;
  logic signed [35:0] s3_t2q;
  logic signed [55:0] s3_lin;
  logic signed [35:0] s3_c;
  logic signed [30:0] s3_dq;
  logic [47:0]        s3_uu;
  logic signed [15:0] s3_temp;
  logic               s3_tsat;
  // stage 4
  logic [23:0]        s4_u;
  logic signed [43:0] s4_t3q;
  logic signed [55:0] s4_lin;
  logic signed [35:0] s4_c;
  logic signed [55:0] s4_udq;
  logic signed [56:0] s4_uup;
  logic signed [15:0] s4_temp;
  logic               s4_tsat;
  // stage 5
  logic [23:0]        s5_u;
  logic signed [55:0] s5_lin;
  logic signed [35:0] s5_c;
  logic signed [60:0] s5_dm;
  logic signed [32:0] s5_eq;
  logic signed [15:0] s5_temp;
  logic               s5_tsat;
  // stage 6
  logic signed [55:0] s6_lin;
  logic signed [60:0] s6_uc;
  logic signed [57:0] s6_eu;
  logic signed [15:0] s6_temp;
  logic               s6_tsat;
  // stage 7
  logic signed [59:0] s7_acc;
  logic signed [15:0] s7_temp;
  logic               s7_tsat;

  logic signed [60:0] dd_t3;
  logic signed [63:0] r40;
  logic signed [63:0] r28;
  logic signed [15:0] temp_c;
  logic               tsat_c;
  logic signed [28:0] tq_c;
  logic signed [57:0] tq_sq;
  logic signed [45:0] p6tq;
  logic signed [17:0] p1m;
  logic signed [17:0] p2m;
  logic signed [46:0] p2tq;
  logic signed [36:0] p10tq;
  logic signed [63:0] t2q_tq;
  logic signed [43:0] p7t2q;
  logic signed [43:0] p3t2q;
  logic signed [51:0] p8t3q;
  logic signed [51:0] p4t3q;
  logic signed [35:0] udq_r;
  logic signed [63:0] pr;
  logic [23:0]        pres_c;
  logic               psat_c;

  assign en  = !out_ch.valid || out_ch.ready;
  assign pop = en && !q_status.empty;

  assign dd_t3 = head.dd * coef.t3;

  always_comb begin
    r40    = btpc_pkg::rnd(64'(s1_tl), 40);
    r28    = btpc_pkg::rnd(64'(s1_tl), 28);
    temp_c = r40[15:0];
    tsat_c = 1'b0;
    if (r40 > btpc_pkg::TEMP_MAX) begin
      temp_c = 16'sh7fff;
      tsat_c = 1'b1;
    end else if (r40 < btpc_pkg::TEMP_MIN) begin
      temp_c = -16'sh8000;
      tsat_c = 1'b1;
    end
    tq_c = r28[28:0];
    if (r28 > btpc_pkg::TQ_LIMIT) begin
      tq_c = 29'(btpc_pkg::TQ_LIMIT);
    end else if (r28 < -btpc_pkg::TQ_LIMIT) begin
      tq_c = 29'(-btpc_pkg::TQ_LIMIT);
    end
  end

  assign tq_sq  = s2_tq * s2_tq;
  assign p6tq   = $signed({1'b0, coef.p6}) * s2_tq;
  assign p1m    = 18'(coef.p1) - 18'sd16384;
  assign p2m    = 18'(coef.p2) - 18'sd16384;
  assign p2tq   = p2m * s2_tq;
  assign p10tq  = coef.p10 * s2_tq;
  assign t2q_tq = s3_t2q * s3_tq;
  assign p7t2q  = coef.p7 * s3_t2q;
  assign p3t2q  = coef.p3 * s3_t2q;
  assign p8t3q  = coef.p8 * s4_t3q;
  assign p4t3q  = coef.p4 * s4_t3q;
  assign udq_r  = 36'(btpc_pkg::rnd(64'(s4_udq), 20));

  always_comb begin
    pr     = btpc_pkg::rnd(64'(s7_acc), 26);
    pres_c = pr[23:0];
    psat_c = 1'b0;
    if (pr < 64'sd0) begin
      pres_c = 24'h000000;
      psat_c = 1'b1;
    end else if (pr > btpc_pkg::PRES_MAX) begin
      pres_c = 24'hffffff;
      psat_c = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      out_ch.valid <= 1'b0;
    end else if (en) begin
      v1 <= !q_status.empty;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
      out_ch.valid <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_u  <= head.u;
      s1_tl <= (61'(head.dt2) <<< 18) + dd_t3;

      s2_u    <= s1_u;
      s2_tq   <= tq_c;
      s2_temp <= temp_c;
      s2_tsat <= tsat_c;

      s3_u    <= s2_u;
      s3_tq   <= s2_tq;
      s3_t2q  <= 36'(btpc_pkg::rnd(64'(tq_sq), 20));
      s3_lin  <= (56'($signed({1'b0, coef.p5})) <<< 35) + (56'(p6tq) <<< 6);
      s3_c    <= 36'((64'(p1m) <<< 16) + btpc_pkg::rnd(64'(p2tq), 13));
      s3_dq   <= 31'((64'(coef.p9) <<< 12) + btpc_pkg::rnd(64'(p10tq), 8));
      s3_uu   <= s2_u * s2_u;
      s3_temp <= s2_temp;
      s3_tsat <= s2_tsat;

      s4_u    <= s3_u;
      s4_t3q  <= 44'(btpc_pkg::rnd(t2q_tq, 20));
      s4_lin  <= s3_lin + (56'(p7t2q) <<< 4);
      s4_c    <= s3_c + 36'(btpc_pkg::rnd(64'(p3t2q), 16));
      s4_udq  <= $signed({1'b0, s3_u}) * s3_dq;
      s4_uup  <= $signed({1'b0, s3_uu}) * coef.p11;
      s4_temp <= s3_temp;
      s4_tsat <= s3_tsat;

      s5_u    <= s4_u;
      s5_lin  <= s4_lin + 56'(btpc_pkg::rnd(64'(p8t3q), 3));
      s5_c    <= s4_c + 36'(btpc_pkg::rnd(64'(p4t3q), 21));
      s5_dm   <= udq_r * $signed({1'b0, s4_u});
      s5_eq   <= 33'(btpc_pkg::rnd(64'(s4_uup), 25));
      s5_temp <= s4_temp;
      s5_tsat <= s4_tsat;

      s6_lin  <= s5_lin + 56'(btpc_pkg::rnd(64'(s5_dm), 8));
      s6_uc   <= $signed({1'b0, s5_u}) * s5_c;
      s6_eu   <= s5_eq * $signed({1'b0, s5_u});
      s6_temp <= s5_temp;
      s6_tsat <= s5_tsat;

      s7_acc  <= 60'(s6_lin) + 60'(btpc_pkg::rnd(64'(s6_uc), 4))
                 + 60'(btpc_pkg::rnd(64'(s6_eu), 8));
      s7_temp <= s6_temp;
      s7_tsat <= s6_tsat;

      out_ch.pressure_out    <= pres_c;
      out_ch.temperature_out <= s7_temp;
      out_ch.saturated       <= psat_c || s7_tsat;
    end
  end

endmodule

@@ test/tb_baro_temp_pressure_compensation.sv @@
// testbench: randomized stream and calibration checks against a fixed-point compensation predictor
`timescale 1ns / 1ps
module tb_baro_temp_pressure_compensation;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 30;

  typedef struct {
    logic [23:0] raw_p;
    logic [23:0] raw_t;
  } sample_t;

  typedef struct {
    logic        [23:0] pres;
    logic signed [15:0] temp;
    logic               sat;
  } comp_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_wdata;

  btpc_in_if  in_ch();
  btpc_out_if out_ch();

  baro_temp_pressure_compensation u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  sample_t     sample_queue[$];
  comp_t       expected_comp[$];
  logic [63:0] cal_low, cal_mid;
  logic [39:0] cal_high;
  int          error_count = 0;
  bit          idle_on = 1;
  int          in_gap = 0;
  int          out_stall = 0;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    error_count++;
  endtask

  function automatic longint round_shift(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic comp_t compensate(input logic [23:0] raw_p, input logic [23:0] raw_t);
    logic [167:0] b;
    longint u, tr, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
    longint d, tl, temp, tq, t2q, t3q, acc, c, dq, eq, pres;
    bit sat;
    comp_t r;
    b = {cal_high, cal_mid, cal_low};
    sat = 0;
    u   = longint'({40'd0, raw_p});
    tr  = longint'({40'd0, raw_t});
    t1  = longint'({48'd0, b[15:0]});
    t2  = longint'({48'd0, b[31:16]});
    t3  = longint'($signed(b[39:32]));
    p1  = longint'($signed(b[55:40]));
    p2  = longint'($signed(b[71:56]));
    p3  = longint'($signed(b[79:72]));
    p4  = longint'($signed(b[87:80]));
    p5  = longint'({48'd0, b[103:88]});
    p6  = longint'({48'd0, b[119:104]});
    p7  = longint'($signed(b[127:120]));
    p8  = longint'($signed(b[135:128]));
    p9  = longint'($signed(b[151:136]));
    p10 = longint'($signed(b[159:152]));
    p11 = longint'($signed(b[167:160]));
    d  = tr - t1 * 256;
    tl = d * t2 * 262144 + d * d * t3;
    temp = round_shift(tl, 40);
    if (temp > 32767) begin
      temp = 32767;
      sat = 1;
    end
    if (temp < -32768) begin
      temp = -32768;
      sat = 1;
    end
    // pressure path sees temperature clamped to +-128 degc
    tq = round_shift(tl, 28);
    if (tq > (longint'(1) <<< 27)) tq = longint'(1) <<< 27;
    if (tq < -(longint'(1) <<< 27)) tq = -(longint'(1) <<< 27);
    t2q = round_shift(tq * tq, 20);
    t3q = round_shift(t2q * tq, 20);
    acc = p5 * (longint'(1) <<< 35) + p6 * tq * 64 + p7 * t2q * 16 + round_shift(p8 * t3q, 3);
    c = (p1 - 16384) * 65536 + round_shift((p2 - 16384) * tq, 13)
        + round_shift(p3 * t2q, 16) + round_shift(p4 * t3q, 21);
    acc += round_shift(u * c, 4);
    dq = p9 * 4096 + round_shift(p10 * tq, 8);
    acc += round_shift(round_shift(u * dq, 20) * u, 8);
    eq = round_shift(u * u * p11, 25);
    acc += round_shift(eq * u, 8);
    pres = round_shift(acc, 26);
    if (pres < 0) begin
      pres = 0;
      sat = 1;
    end
    if (pres > 64'sd16777215) begin
      pres = 64'sd16777215;
      sat = 1;
    end
    r.pres = pres[23:0];
    r.temp = temp[15:0];
    r.sat  = sat;
    return r;
  endfunction

  // calibration shadow
  always @(posedge clk) begin
    if (rst) begin
      cal_low  <= '0;
      cal_mid  <= '0;
      cal_high <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        btpc_pkg::CFG_CAL_LOW:  cal_low  <= cfg_wdata;
        btpc_pkg::CFG_CAL_MID:  cal_mid  <= cfg_wdata;
        btpc_pkg::CFG_CAL_HIGH: cal_high <= cfg_wdata[39:0];
        default: ;
      endcase
    end
  end

  // sample driver
  always @(posedge clk) begin
    sample_t s;
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.raw_pressure <= '0;
      in_ch.raw_temperature <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (sample_queue.size() > 0) begin
        s = sample_queue.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.raw_pressure <= s.raw_p;
        in_ch.raw_temperature <= s.raw_t;
        if (idle_on && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 5);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // prediction on each accepted transaction
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready)
      expected_comp.push_back(compensate(in_ch.raw_pressure, in_ch.raw_temperature));
  end

  // result side backpressure
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (idle_on && $urandom_range(0, 6) == 0) out_stall = $urandom_range(1, 5);
    end
  end

  // result checker
  always @(posedge clk) begin
    comp_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_comp.size() == 0) begin
        report("result transaction with nothing expected");
      end else begin
        e = expected_comp.pop_front();
        if (out_ch.pressure_out !== e.pres)
          report($sformatf("pressure got %0d exp %0d", out_ch.pressure_out, e.pres));
        if (out_ch.temperature_out !== e.temp)
          report($sformatf("temperature got %0d exp %0d", out_ch.temperature_out, e.temp));
        if (out_ch.saturated !== e.sat)
          report($sformatf("saturated got %0b exp %0b", out_ch.saturated, e.sat));
      end
    end
  end

  task automatic write_cal(input logic [1:0] idx, input logic [63:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic add_sample(input logic [23:0] p, input logic [23:0] t);
    sample_t s;
    s.raw_p = p;
    s.raw_t = t;
    sample_queue.push_back(s);
  endtask

  task automatic drain();
    while (sample_queue.size() > 0 || in_ch.valid || expected_comp.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [167:0] typical_cal();
    // t1 t2 t3 p1 p2 p3 p4 p5 p6 p7 p8 p9 p10 p11, low byte first
    return {-8'sd60, 8'sd30, 16'sd16000, -8'sd10, 8'sd40, 16'd17000, 16'd27000,
            8'sd5, 8'sd35, -16'sd11000, -16'sd2500, -8'sd7, 16'd19000, 16'd27000};
  endfunction

  initial begin
    logic [167:0] cal;
    logic [167:0] typ;
    logic [23:0]  tcenter;
    cfg_we    = 1'b0;
    cfg_index = btpc_pkg::CFG_CAL_LOW;
    cfg_wdata = '0;
    rst = 1'b1;
    typ = typical_cal();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: cal = '0;
        1: cal = '1;
        2: cal = typ;
        3: cal = '0;
        default: cal = 168'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      endcase
      if (ph >= 5) cal[15:0] = typ[15:0];
      if (ph != 0) begin
        write_cal(btpc_pkg::CFG_CAL_LOW, cal[63:0]);
        write_cal(btpc_pkg::CFG_CAL_MID, cal[127:64]);
        write_cal(btpc_pkg::CFG_CAL_HIGH, {24'hffffff, cal[167:128]});
      end
      if (ph == 3) write_cal(CFG_UNUSED, {$urandom, $urandom});
      idle_on = (ph != 7);
      tcenter = {cal[15:0], 8'd0};
      add_sample(24'd0, 24'd0);
      add_sample(24'hffffff, 24'hffffff);
      add_sample(24'hffffff, 24'd0);
      add_sample(24'd0, 24'hffffff);
      add_sample(24'h800000, tcenter);
      add_sample(24'h6b0000, tcenter + 24'd4000);
      for (int i = 0; i < 50; i++) begin
        if ($urandom_range(0, 1))
          add_sample(24'($urandom), tcenter + 24'($urandom_range(0, 131072)) - 24'd65536);
        else
          add_sample(24'($urandom), 24'($urandom));
      end
      drain();
    end
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("FAILURE");
    $finish;
  end

endmodule
